// File: hdl/alrp_pkg.sv
`timescale 1ns / 1ps

package alrp_pkg;

  // Store geometry: one entry per loop sample, positions in Q20.16
  localparam int AddrWidth   = 19;
  localparam int LoopSamples = 2 ** AddrWidth;
  localparam int SampleWidth = 16;
  localparam int PosWidth    = 36;
  localparam int RecWidth    = 20;

  // Fade-in length in samples; a power of two so the divide is a shift
  localparam int FadeLength = 32;
  localparam int FadeShift  = $clog2(FadeLength);
  localparam int FadeOne    = 65536;

  localparam int SpeedMin = 6554;
  localparam int SpeedMax = 262144;
  localparam int GainMax  = 32768;

  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 20;

  localparam logic [CfgIdxWidth-1:0] CfgLoopBegin  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLoopFinish = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgBaseSpeed  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgBaseGain   = 3'd3;

  typedef enum logic [1:0] {
    ModeStop    = 2'd0,
    ModeRecord  = 2'd1,
    ModePlay    = 2'd2,
    ModeOverdub = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqRecWrite,
    SeqOdRead,
    SeqOdWrite,
    SeqRd0,
    SeqRd1,
    SeqFetch1,
    SeqLaunch
  } seq_state_e;

  typedef struct packed {
    logic                          en;
    logic [AddrWidth-1:0]          addr;
    logic signed [SampleWidth-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic                          start;
    logic signed [SampleWidth-1:0] s0;
    logic signed [SampleWidth-1:0] s1;
    logic [15:0]                   frac;
    logic [16:0]                   fade;
    logic [15:0]                   gain;
    logic [AddrWidth-1:0]          index;
  } math_req_t;

  typedef struct packed {
    logic                          valid;
    logic signed [SampleWidth-1:0] sample;
    logic [AddrWidth-1:0]          index;
  } math_res_t;

endpackage

// File: hdl/audio_loop_recorder_player_core.sv
// Loop recorder and player, one audio word per handshake.
// Slave stream: tuser carries the mode (stop, record, play, overdub); tdata carries
// the input sample, speed modulation and gain modulation. Master stream: tdata
// carries the output sample and the integer read position after the word.
// Configuration channel writes loop begin, loop finish, base speed and base gain
// by index; take writes only while the block is idle, ahead of a waiting input word.
// Each word is worked in steps on one sample memory with one read and one write
// port: record writes once, play reads two neighbors, overdub reads, writes the
// sum and then reads two neighbors. A four-stage multiply pipeline scales the
// interpolated value by fade and gain, one word at a time.
// A new word is accepted once the previous one has been launched; the word rate is
// set by the store port steps and the multiply pipeline holding a single word.
// After reset every memory entry is swept to zero; s_axis_tready stays low during
// that pass while configuration writes are still taken.
// When the receiver stalls the finished word waits in the output register; the
// next word is accepted and worked up to the multiply launch, then held there.
`timescale 1ns / 1ps

module audio_loop_recorder_player_core import alrp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [47:0]             s_axis_tdata,  // in_sample, speed_mod, gain_mod
  input  logic [1:0]              s_axis_tuser,  // mode
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [39:0]             m_axis_tdata,  // out_sample, play_index, zero pad
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  logic                          store_busy;
  logic signed [SampleWidth-1:0] rd_data;
  logic [AddrWidth-1:0]          rd_addr;
  store_wr_t                     wr;
  math_req_t                     req;
  math_res_t                     res;
  logic                          math_busy;
  logic                          slot_free;

  logic                          m_valid_q, m_valid_d;
  logic signed [SampleWidth-1:0] out_sample_q;
  logic [AddrWidth-1:0]          play_index_q;

  alrp_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .busy_o    (store_busy)
  );

  alrp_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tuser),
    .in_sample_i  ($signed(s_axis_tdata[15:0])),
    .speed_mod_i  ($signed(s_axis_tdata[31:16])),
    .gain_mod_i   ($signed(s_axis_tdata[47:32])),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .store_busy_i (store_busy),
    .rd_data_i    (rd_data),
    .rd_addr_o    (rd_addr),
    .wr_o         (wr),
    .slot_free_i  (slot_free),
    .math_busy_i  (math_busy),
    .req_o        (req)
  );

  alrp_math u_math (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .busy_o (math_busy)
  );

  assign slot_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res.valid) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_sample_q <= res.sample;
      play_index_q <= res.index;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b00000, play_index_q, out_sample_q};

  // A finished word never lands on an occupied output register
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!m_valid_q || m_axis_tready))
    else $error("result arrived while output word still pending");

  // One word in work at a time
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("word accepted while previous word in work");

  // Nothing is in flight while the memory is being cleared
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> (!m_valid_q && !math_busy && !s_axis_tready))
    else $error("activity during memory clear");

endmodule

// File: hdl/alrp_store.sv
`timescale 1ns / 1ps

module alrp_store import alrp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  store_wr_t                     wr_i,
  input  logic [AddrWidth-1:0]          rd_addr_i,
  output logic signed [SampleWidth-1:0] rd_data_o,
  output logic                          busy_o
);

  logic signed [SampleWidth-1:0] mem [LoopSamples];
  logic signed [SampleWidth-1:0] rd_data_q;

  logic                 clr_busy_q, clr_busy_d;
  logic [AddrWidth-1:0] clr_addr_q, clr_addr_d;
  store_wr_t            port_wr;

  // Sweep every entry to zero after reset
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == {AddrWidth{1'b1}}) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_comb begin
    port_wr = wr_i;
    if (clr_busy_q) begin
      port_wr.en   = 1'b1;
      port_wr.addr = clr_addr_q;
      port_wr.data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (port_wr.en) begin
      mem[port_wr.addr] <= port_wr.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

// File: hdl/alrp_math.sv
`timescale 1ns / 1ps

module alrp_math import alrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  math_req_t req_i,
  output math_res_t res_o,
  output logic      busy_o
);

  logic [3:0] vld_q;

  logic [16:0]        w0;
  logic signed [32:0] p0, p1;
  logic signed [32:0] p0_q, p1_q;
  logic [16:0]        fade1_q, fade2_q;
  logic [15:0]        gain1_q, gain2_q, gain3_q;
  logic [AddrWidth-1:0] idx1_q, idx2_q, idx3_q, idx4_q;

  logic signed [33:0] vsum;
  logic signed [32:0] v_q;
  logic signed [48:0] t, t_q;
  logic signed [63:0] prod, prod_q;
  logic signed [16:0] q;
  logic signed [SampleWidth-1:0] sat;

  // Stage 1: weight the two neighbors by the fraction
  assign w0 = 17'(FadeOne) - {1'b0, req_i.frac};
  assign p0 = req_i.s0 * $signed({1'b0, w0});
  assign p1 = req_i.s1 * $signed({2'b00, req_i.frac});

  // Stage 2: interpolated value, |v| <= 2^31
  assign vsum = {p0_q[32], p0_q} + {p1_q[32], p1_q};

  // Stage 3 and 4: fade, then gain
  assign t    = v_q * $signed({1'b0, fade2_q});
  assign prod = t_q * $signed({1'b0, gain3_q});

  // Floor divide by 2^47 is the upper bits; saturate to 16 bits
  assign q = prod_q[63:47];
  always_comb begin
    sat = q[15:0];
    if (q[16] != q[15]) begin
      sat = q[16] ? $signed(16'h8000) : $signed(16'h7fff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_i.start};
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q    <= p0;
    p1_q    <= p1;
    fade1_q <= req_i.fade;
    gain1_q <= req_i.gain;
    idx1_q  <= req_i.index;

    v_q     <= $signed(vsum[32:0]);
    fade2_q <= fade1_q;
    gain2_q <= gain1_q;
    idx2_q  <= idx1_q;

    t_q     <= t;
    gain3_q <= gain2_q;
    idx3_q  <= idx2_q;

    prod_q  <= prod;
    idx4_q  <= idx3_q;
  end

  assign res_o.valid  = vld_q[3];
  assign res_o.sample = sat;
  assign res_o.index  = idx4_q;
  assign busy_o       = |vld_q;

endmodule

// File: hdl/alrp_seq.sv
`timescale 1ns / 1ps

module alrp_seq import alrp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_mode_i,
  input  logic signed [SampleWidth-1:0] in_sample_i,
  input  logic signed [15:0]            speed_mod_i,
  input  logic signed [15:0]            gain_mod_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]        cfg_index_i,
  input  logic [CfgDataWidth-1:0]       cfg_data_i,
  input  logic                          store_busy_i,
  input  logic signed [SampleWidth-1:0] rd_data_i,
  output logic [AddrWidth-1:0]          rd_addr_o,
  output store_wr_t                     wr_o,
  input  logic                          slot_free_i,
  input  logic                          math_busy_i,
  output math_req_t                     req_o
);

  localparam logic signed [20:0] SpdLo = 21'(SpeedMin);
  localparam logic signed [20:0] SpdHi = 21'(SpeedMax);
  localparam logic signed [17:0] GainHi = 18'(GainMax);

  seq_state_e state_q, state_d;
  mode_e      mode_q, mode_d;

  logic signed [SampleWidth-1:0] smp_q, smp_d;
  logic signed [SampleWidth-1:0] s0_q, s0_d, s1_q, s1_d;
  logic [18:0]          speed_q, speed_d;
  logic [15:0]          gain_q, gain_d;
  logic [15:0]          frac_q, frac_d;
  logic [16:0]          fade_q, fade_d;
  logic [PosWidth-1:0]  pp_q, pp_d;
  logic [RecWidth-1:0]  rp_q, rp_d;

  logic [18:0] begin_q, begin_d;
  logic [19:0] finish_q, finish_d;
  logic [18:0] bspeed_q, bspeed_d;
  logic [15:0] bgain_q, bgain_d;

  logic [18:0] nb, ns;
  logic [19:0] nf, nf_lim;
  logic [15:0] ng;

  logic signed [20:0] spd_sum;
  logic signed [17:0] gain_sum;
  logic signed [16:0] od_sum;
  logic signed [SampleWidth-1:0] od_sat;
  logic [RecWidth-1:0] rp_inc, rp_adv;
  logic [PosWidth-1:0] pp_sum, pp_adv, b16, win, diff;
  logic [19:0]         begin_win;
  logic [16:0]         fade_calc;
  logic [AddrWidth-1:0] i0;

  assign i0 = pp_q[AddrWidth+15:16];

  // Per-word speed and gain with clamping
  assign spd_sum  = $signed({2'b00, bspeed_q}) + $signed({{2{speed_mod_i[15]}}, speed_mod_i, 3'b000});
  assign gain_sum = $signed({2'b00, bgain_q}) + $signed({{2{gain_mod_i[15]}}, gain_mod_i});

  // Overdub sum with saturation
  assign od_sum = {rd_data_i[15], rd_data_i} + {smp_q[15], smp_q};
  always_comb begin
    od_sat = od_sum[15:0];
    if (od_sum[16] != od_sum[15]) begin
      od_sat = od_sum[16] ? $signed(16'h8000) : $signed(16'h7fff);
    end
  end

  // Write position: step, return to loop start at loop end
  assign rp_inc = rp_q + 1'b1;
  assign rp_adv = (rp_inc >= finish_q) ? {1'b0, begin_q} : rp_inc;

  // Read position: step by speed, return to loop start at loop end
  assign pp_sum = pp_q + PosWidth'(speed_q);
  assign pp_adv = (pp_sum >= {finish_q, 16'h0000}) ? {1'b0, begin_q, 16'h0000} : pp_sum;

  // Fade-in ramp over the first loop samples
  assign b16       = {1'b0, begin_q, 16'h0000};
  assign begin_win = {1'b0, begin_q} + 20'(FadeLength);
  assign win       = {begin_win, 16'h0000};
  assign diff      = pp_q - b16;
  always_comb begin
    if (pp_q < b16) begin
      fade_calc = '0;
    end else if (pp_q < win) begin
      fade_calc = 17'(diff >> FadeShift);
    end else begin
      fade_calc = 17'(FadeOne);
    end
  end

  // Configuration writes, normalized
  always_comb begin
    nb = begin_q;
    nf = finish_q;
    ns = bspeed_q;
    ng = bgain_q;
    cfg_ready_o = (state_q == SeqIdle);
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgLoopBegin:  nb = cfg_data_i[18:0];
        CfgLoopFinish: nf = cfg_data_i;
        CfgBaseSpeed:  ns = cfg_data_i[18:0];
        CfgBaseGain:   ng = cfg_data_i[15:0];
        default: ;
      endcase
    end
    begin_d  = nb;
    nf_lim   = (nf > 20'(LoopSamples)) ? 20'(LoopSamples) : nf;
    finish_d = (nf_lim < {1'b0, nb}) ? ({1'b0, nb} + 1'b1) : nf_lim;
    if (ns < 19'(SpeedMin)) begin
      bspeed_d = 19'(SpeedMin);
    end else if (ns > 19'(SpeedMax)) begin
      bspeed_d = 19'(SpeedMax);
    end else begin
      bspeed_d = ns;
    end
    bgain_d = (ng > 16'(GainMax)) ? 16'(GainMax) : ng;
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    smp_d   = smp_q;
    speed_d = speed_q;
    gain_d  = gain_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    frac_d  = frac_q;
    fade_d  = fade_q;
    pp_d    = pp_q;
    rp_d    = rp_q;

    in_ready_o = 1'b0;
    rd_addr_o  = i0;
    wr_o.en    = 1'b0;
    wr_o.addr  = rp_q[AddrWidth-1:0];
    wr_o.data  = smp_q;

    req_o.start = 1'b0;
    req_o.s0    = s0_q;
    req_o.s1    = s1_q;
    req_o.frac  = frac_q;
    req_o.fade  = fade_q;
    req_o.gain  = gain_q;
    req_o.index = pp_q[AddrWidth+15:16];

    case (state_q)
      SeqIdle: begin
        // A pending configuration write goes first; hold the input word
        in_ready_o = !store_busy_i && !cfg_valid_i;
        if (in_valid_i && in_ready_o) begin
          mode_d = mode_e'(in_mode_i);
          smp_d  = in_sample_i;
          if (spd_sum < SpdLo) begin
            speed_d = 19'(SpeedMin);
          end else if (spd_sum > SpdHi) begin
            speed_d = 19'(SpeedMax);
          end else begin
            speed_d = spd_sum[18:0];
          end
          if (gain_sum < 0) begin
            gain_d = '0;
          end else if (gain_sum > GainHi) begin
            gain_d = 16'(GainMax);
          end else begin
            gain_d = gain_sum[15:0];
          end
          s0_d   = '0;
          s1_d   = '0;
          frac_d = '0;
          fade_d = 17'(FadeOne);
          case (mode_d)
            ModeStop:    state_d = SeqLaunch;
            ModeRecord:  state_d = SeqRecWrite;
            ModePlay:    state_d = SeqRd0;
            ModeOverdub: state_d = SeqOdRead;
            default:     state_d = SeqLaunch;
          endcase
        end
      end
      SeqRecWrite: begin
        // Echo goes through the multiplier as s0 at full weight
        wr_o.en = 1'b1;
        s0_d    = smp_q;
        rp_d    = rp_adv;
        state_d = SeqLaunch;
      end
      SeqOdRead: begin
        rd_addr_o = rp_q[AddrWidth-1:0];
        state_d   = SeqOdWrite;
      end
      SeqOdWrite: begin
        wr_o.en   = 1'b1;
        wr_o.data = od_sat;
        rp_d      = rp_adv;
        state_d   = SeqRd0;
      end
      SeqRd0: begin
        // Write above has landed, so this read sees the overdub sum
        rd_addr_o = i0;
        frac_d    = pp_q[15:0];
        fade_d    = (mode_q == ModePlay) ? fade_calc : 17'(FadeOne);
        state_d   = SeqRd1;
      end
      SeqRd1: begin
        rd_addr_o = i0 + 1'b1;
        s0_d      = rd_data_i;
        state_d   = SeqFetch1;
      end
      SeqFetch1: begin
        s1_d    = rd_data_i;
        pp_d    = pp_adv;
        state_d = SeqLaunch;
      end
      SeqLaunch: begin
        // Hold until the multiplier and output slot are both free
        if (!math_busy_i && slot_free_i) begin
          req_o.start = 1'b1;
          state_d     = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SeqIdle;
      mode_q   <= ModeStop;
      pp_q     <= '0;
      rp_q     <= '0;
      begin_q  <= '0;
      finish_q <= 20'(LoopSamples);
      bspeed_q <= 19'(65536);
      bgain_q  <= 16'(GainMax);
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      pp_q     <= pp_d;
      rp_q     <= rp_d;
      begin_q  <= begin_d;
      finish_q <= finish_d;
      bspeed_q <= bspeed_d;
      bgain_q  <= bgain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q   <= smp_d;
    speed_q <= speed_d;
    gain_q  <= gain_d;
    s0_q    <= s0_d;
    s1_q    <= s1_d;
    frac_q  <= frac_d;
    fade_q  <= fade_d;
  end

endmodule
